// ===== rtl/core/ledsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledsp_pkg
// Shared types and constants for the LED status pattern driver: transaction
// payloads, command and mode codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ledsp_pkg;

    // elapsed-time counter width (supported range 8 to 32)
    localparam int TIMER_BITS = 12;
    localparam int PERIOD_W   = 12;
    localparam int BURST_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int CMP_W      = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;
    localparam int NUM_LEDS   = 4;

    // led slots
    localparam int LED_LINK   = 0;
    localparam int LED_CLOCK  = 1;
    localparam int LED_HEART  = 2;
    localparam int LED_STATUS = 3;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // status modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_FAST  = 2'd1;
    localparam logic [1:0] MODE_BURST = 2'd2;
    localparam logic [1:0] MODE_SOLID = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINK_BLINK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_BLINK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_BLINK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_BLINK = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_COUNT = 3'd5;

    // register reset values
    localparam logic [PERIOD_W-1:0] RST_LINK_BLINK  = 12'd500;
    localparam logic [PERIOD_W-1:0] RST_CLOCK_BLINK = 12'd1500;
    localparam logic [PERIOD_W-1:0] RST_HEARTBEAT   = 12'd1000;
    localparam logic [PERIOD_W-1:0] RST_FAST_BLINK  = 12'd150;
    localparam logic [PERIOD_W-1:0] RST_BURST_BLINK = 12'd200;
    localparam logic [BURST_W-1:0]  RST_BURST_COUNT = 4'd3;

    typedef struct packed {
        logic [1:0] command;
        logic       link_connected;
        logic       link_connecting;
        logic       clock_lost_power;
        logic [1:0] new_status;
    } t_in_item;

    typedef struct packed {
        logic       link_led;
        logic       clock_led;
        logic       heartbeat_led;
        logic       status_led;
        logic [1:0] status_mode;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

endpackage

// ===== rtl/core/ledsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ledsp interfaces
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
interface ledsp_in_if;
    logic                 valid;
    logic                 ready;
    ledsp_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ledsp_out_if;
    logic                 valid;
    logic                 ready;
    ledsp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ledsp_cfg_if;
    logic                 valid;
    logic                 ready;
    ledsp_pkg::t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/led_status_pattern_driver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_status_pattern_driver_top
// Drives link, clock-health, heartbeat and status LEDs from tick and status
// commands, with one result transaction for every command transaction.
// ----------------------------------------------------------------------------
// The LED state and the result register are updated at the edge where the
// command is accepted, so a new command is taken in every cycle while the
// result register is empty or being drained; a result that waits stalls input
// for as long as it waits. Result valid rises in the cycle after the accept.
// Register writes are always accepted and take effect from the next command.
module led_status_pattern_driver_top (
    input  logic i_clk,
    input  logic i_rst_n,
    ledsp_in_if.sink    i_in,
    ledsp_out_if.source o_out,
    ledsp_cfg_if.sink   i_cfg
);
    import ledsp_pkg::*;

    // configuration registers
    logic [PERIOD_W-1:0] r_link_blink;
    logic [PERIOD_W-1:0] r_clock_blink;
    logic [PERIOD_W-1:0] r_heartbeat;
    logic [PERIOD_W-1:0] r_fast_blink;
    logic [PERIOD_W-1:0] r_burst_blink;
    logic [BURST_W-1:0]  r_burst_count;

    // led state
    logic [NUM_LEDS-1:0]   r_led;
    logic [NUM_LEDS-1:0]   n_led;
    logic [TIMER_BITS-1:0] r_cnt [NUM_LEDS];
    logic [TIMER_BITS-1:0] n_cnt [NUM_LEDS];
    logic [1:0]            r_mode;
    logic [1:0]            n_mode;
    logic [BURST_W-1:0]    r_blinks;
    logic [BURST_W-1:0]    n_blinks;

    // result register
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // tick helpers
    logic [TIMER_BITS-1:0] inc_cnt [NUM_LEDS];
    logic [PERIOD_W-1:0]   period  [NUM_LEDS];
    logic [NUM_LEDS-1:0]   due;
    logic [PERIOD_W-1:0]   status_period;

    logic in_acc;
    logic cfg_acc;

    // handshakes
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_blink  <= RST_LINK_BLINK;
            r_clock_blink <= RST_CLOCK_BLINK;
            r_heartbeat   <= RST_HEARTBEAT;
            r_fast_blink  <= RST_FAST_BLINK;
            r_burst_blink <= RST_BURST_BLINK;
            r_burst_count <= RST_BURST_COUNT;
        end else if (cfg_acc) begin
            case (i_cfg.data.index)
                REG_LINK_BLINK:  r_link_blink  <= i_cfg.data.data;
                REG_CLOCK_BLINK: r_clock_blink <= i_cfg.data.data;
                REG_HEARTBEAT:   r_heartbeat   <= i_cfg.data.data;
                REG_FAST_BLINK:  r_fast_blink  <= i_cfg.data.data;
                REG_BURST_BLINK: r_burst_blink <= i_cfg.data.data;
                REG_BURST_COUNT: r_burst_count <= i_cfg.data.data[BURST_W-1:0];
                default: ;
            endcase
        end
    end

    // period per led and status period by mode
    assign status_period = (r_mode == MODE_BURST) ? r_burst_blink : r_fast_blink;
    assign period[LED_LINK]   = r_link_blink;
    assign period[LED_CLOCK]  = r_clock_blink;
    assign period[LED_HEART]  = r_heartbeat;
    assign period[LED_STATUS] = status_period;

    // saturating advance and due compare
    always_comb begin
        for (int i = 0; i < NUM_LEDS; i++) begin
            inc_cnt[i] = (r_cnt[i] == {TIMER_BITS{1'b1}}) ? r_cnt[i]
                                                          : r_cnt[i] + 1'b1;
            due[i] = CMP_W'(inc_cnt[i]) >= CMP_W'(period[i]);
        end
    end

    // next state for one command
    always_comb begin
        n_led    = r_led;
        n_mode   = r_mode;
        n_blinks = r_blinks;
        for (int i = 0; i < NUM_LEDS; i++) begin
            n_cnt[i] = r_cnt[i];
        end

        case (i_in.data.command)
            CMD_TICK: begin
                for (int i = 0; i < NUM_LEDS; i++) begin
                    n_cnt[i] = inc_cnt[i];
                end

                // link led
                if (i_in.data.link_connected) begin
                    n_led[LED_LINK] = 1'b1;
                end else if (i_in.data.link_connecting) begin
                    if (due[LED_LINK]) begin
                        n_led[LED_LINK] = !r_led[LED_LINK];
                        n_cnt[LED_LINK] = '0;
                    end
                end else begin
                    n_led[LED_LINK] = 1'b0;
                end

                // clock led
                if (!i_in.data.clock_lost_power) begin
                    n_led[LED_CLOCK] = 1'b1;
                end else if (due[LED_CLOCK]) begin
                    n_led[LED_CLOCK] = !r_led[LED_CLOCK];
                    n_cnt[LED_CLOCK] = '0;
                end

                // heartbeat led
                if (due[LED_HEART]) begin
                    n_led[LED_HEART] = !r_led[LED_HEART];
                    n_cnt[LED_HEART] = '0;
                end

                // status led
                case (r_mode)
                    MODE_FAST: begin
                        if (due[LED_STATUS]) begin
                            n_led[LED_STATUS] = !r_led[LED_STATUS];
                            n_cnt[LED_STATUS] = '0;
                        end
                    end
                    MODE_BURST: begin
                        if (r_blinks != '0) begin
                            if (due[LED_STATUS]) begin
                                n_led[LED_STATUS] = !r_led[LED_STATUS];
                                n_cnt[LED_STATUS] = '0;
                                // a toggle to off ends one blink
                                if (r_led[LED_STATUS]) begin
                                    n_blinks = r_blinks - 1'b1;
                                end
                            end
                        end else begin
                            n_led[LED_STATUS] = 1'b0;
                            n_mode            = MODE_NONE;
                        end
                    end
                    MODE_SOLID: n_led[LED_STATUS] = 1'b1;
                    default:    n_led[LED_STATUS] = 1'b0;
                endcase
            end
            CMD_SET: begin
                n_mode            = i_in.data.new_status;
                n_cnt[LED_STATUS] = '0;
                if (i_in.data.new_status == MODE_BURST) begin
                    n_blinks = r_burst_count;
                end
            end
            CMD_CLEAR: begin
                n_mode            = MODE_NONE;
                n_led[LED_STATUS] = 1'b0;
            end
            default: ;
        endcase

        n_out.link_led      = n_led[LED_LINK];
        n_out.clock_led     = n_led[LED_CLOCK];
        n_out.heartbeat_led = n_led[LED_HEART];
        n_out.status_led    = n_led[LED_STATUS];
        n_out.status_mode   = n_mode;
    end

    // state update on accepted command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led    <= '0;
            r_mode   <= MODE_NONE;
            r_blinks <= '0;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (in_acc) begin
            r_led    <= n_led;
            r_mode   <= n_mode;
            r_blinks <= n_blinks;
            for (int i = 0; i < NUM_LEDS; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    // clear forces the status led off and mode to none
    a_clear_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.data.command == CMD_CLEAR)
        |=> (r_out.status_led == 1'b0 && r_out.status_mode == MODE_NONE))
        else $error("clear did not force status off");

    // set reports the requested mode
    a_set_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.data.command == CMD_SET)
        |=> (r_out.status_mode == $past(i_in.data.new_status)))
        else $error("set did not load status mode");

    // connected link is solid on after a tick
    a_link_solid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.data.command == CMD_TICK && i_in.data.link_connected)
        |=> (r_out.link_led == 1'b1 && r_led[LED_LINK] == 1'b1))
        else $error("connected link led not on");

    // result register and led state agree after every accepted command
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_out.status_led == r_led[LED_STATUS]
                    && r_out.status_mode == r_mode && r_out_valid))
        else $error("result register out of step with state");

endmodule

// ===== tb/sv/tb_led_status_pattern_driver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_status_pattern_driver_top
// Self-checking bench for the LED status pattern driver. A local LED model
// predicts every result transaction from the accepted command transactions and
// the register writes. The bench runs a directed pass over the special cases,
// then randomized phases under several register settings (zero, one, short, mid,
// full-range and the longest periods) with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_led_status_pattern_driver_top;
    import ledsp_pkg::*;

    // command code the block leaves unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // register indexes the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // sender and receiver styles
    localparam int SEND_STEADY  = 0;
    localparam int SEND_BURSTY  = 1;
    localparam int SEND_CHOPPY  = 2;
    localparam int RECV_FREE    = 0;
    localparam int RECV_RANDOM  = 1;
    localparam int RECV_PATTERN = 2;

    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 275;
    localparam logic [TIMER_BITS-1:0] TICK_MAX = {TIMER_BITS{1'b1}};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // bench-side drive registers
    logic                 cmd_valid    = 1'b0;
    t_in_item             cmd_data     = '0;
    logic                 res_ready    = 1'b0;
    logic                 reg_wr_valid = 1'b0;
    t_cfg_item            reg_wr_data  = '0;

    ledsp_in_if  in_if ();
    ledsp_out_if out_if ();
    ledsp_cfg_if cfg_if ();

    assign in_if.valid  = cmd_valid;
    assign in_if.data   = cmd_data;
    assign out_if.ready = res_ready;
    assign cfg_if.valid = reg_wr_valid;
    assign cfg_if.data  = reg_wr_data;

    led_status_pattern_driver_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // LED model state and register copies
    // ------------------------------------------------------------------
    logic                  led_on      [NUM_LEDS];
    logic [TIMER_BITS-1:0] since_toggle[NUM_LEDS];
    logic [1:0]            mode_now;
    logic [BURST_W-1:0]    blinks_rem;

    logic [PERIOD_W-1:0] link_period  = RST_LINK_BLINK;
    logic [PERIOD_W-1:0] clock_period = RST_CLOCK_BLINK;
    logic [PERIOD_W-1:0] heart_period = RST_HEARTBEAT;
    logic [PERIOD_W-1:0] fast_period  = RST_FAST_BLINK;
    logic [PERIOD_W-1:0] burst_period = RST_BURST_BLINK;
    logic [BURST_W-1:0]  burst_len    = RST_BURST_COUNT;

    t_in_item  pending_cmds[$];
    t_out_item expected_leds[$];

    int  err_count   = 0;
    int  cmd_count   = 0;
    int  res_count   = 0;
    int  reg_count   = 0;
    int  idle_cycles = 0;
    bit  cmd_taken   = 1'b0;

    // sender, receiver and stimulus controls
    int  send_style  = SEND_STEADY;
    int  recv_style  = RECV_FREE;
    int  burst_left  = 0;
    int  gap_left    = 0;
    int  hold_left   = 0;
    int  recv_step   = 0;
    bit  hold_req    = 1'b0;
    logic lk_conn    = 1'b0;
    logic lk_try     = 1'b0;
    logic clk_lost   = 1'b0;

    initial begin
        for (int i = 0; i < NUM_LEDS; i++) begin
            led_on[i]       = 1'b0;
            since_toggle[i] = '0;
        end
        mode_now   = MODE_NONE;
        blinks_rem = '0;
    end

    // toggle one LED when its counter has reached the period
    function automatic bit toggle_when_due(input int slot, input logic [PERIOD_W-1:0] period);
        if (since_toggle[slot] >= period) begin
            led_on[slot]       = ~led_on[slot];
            since_toggle[slot] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the LED model by one command and form the expected result
    task automatic advance_leds(input t_in_item c, output t_out_item r);
        case (c.command)
            CMD_TICK: begin
                for (int i = 0; i < NUM_LEDS; i++)
                    if (since_toggle[i] != TICK_MAX) since_toggle[i] = since_toggle[i] + 1'b1;
                // connected wins over connecting
                if (c.link_connected)
                    led_on[LED_LINK] = 1'b1;
                else if (c.link_connecting)
                    void'(toggle_when_due(LED_LINK, link_period));
                else
                    led_on[LED_LINK] = 1'b0;
                if (!c.clock_lost_power)
                    led_on[LED_CLOCK] = 1'b1;
                else
                    void'(toggle_when_due(LED_CLOCK, clock_period));
                void'(toggle_when_due(LED_HEART, heart_period));
                case (mode_now)
                    MODE_FAST: void'(toggle_when_due(LED_STATUS, fast_period));
                    MODE_BURST: begin
                        // a blink is counted when the LED goes back off
                        if (blinks_rem != 0) begin
                            if (toggle_when_due(LED_STATUS, burst_period)) begin
                                if (!led_on[LED_STATUS]) blinks_rem = blinks_rem - 1'b1;
                            end
                        end else begin
                            led_on[LED_STATUS] = 1'b0;
                            mode_now = MODE_NONE;
                        end
                    end
                    MODE_SOLID: led_on[LED_STATUS] = 1'b1;
                    default: led_on[LED_STATUS] = 1'b0;
                endcase
            end
            CMD_SET: begin
                mode_now = c.new_status;
                since_toggle[LED_STATUS] = '0;
                if (c.new_status == MODE_BURST) blinks_rem = burst_len;
            end
            CMD_CLEAR: begin
                mode_now = MODE_NONE;
                led_on[LED_STATUS] = 1'b0;
            end
            default: ;
        endcase
        r.link_led      = led_on[LED_LINK];
        r.clock_led     = led_on[LED_CLOCK];
        r.heartbeat_led = led_on[LED_HEART];
        r.status_led    = led_on[LED_STATUS];
        r.status_mode   = mode_now;
    endtask

    // register write into the local copies, values masked to width
    task automatic apply_reg_write(input t_cfg_item w);
        case (w.index)
            REG_LINK_BLINK:  link_period  = w.data;
            REG_CLOCK_BLINK: clock_period = w.data;
            REG_HEARTBEAT:   heart_period = w.data;
            REG_FAST_BLINK:  fast_period  = w.data;
            REG_BURST_BLINK: burst_period = w.data;
            REG_BURST_COUNT: burst_len    = w.data[BURST_W-1:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // monitor: register writes, command transactions, result check, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            t_out_item want;
            idle_cycles++;
            if (reg_wr_valid && cfg_if.ready) begin
                apply_reg_write(reg_wr_data);
                reg_count++;
                idle_cycles = 0;
            end
            // compare before the new prediction is queued
            if (out_if.valid && res_ready) begin
                idle_cycles = 0;
                res_count++;
                if (expected_leds.size() == 0) begin
                    $display("%0t ns: result expected none actual %h", $time, out_if.data);
                    err_count++;
                end else begin
                    want = expected_leds.pop_front();
                    if (want != out_if.data) begin
                        $display("%0t ns: result expected %h actual %h",
                                 $time, want, out_if.data);
                        err_count++;
                    end
                end
            end
            if (cmd_valid && in_if.ready) begin
                advance_leds(cmd_data, want);
                expected_leds.push_back(want);
                cmd_taken = 1'b1;
                cmd_count++;
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: offers pending commands in bursts with gaps
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            if (cmd_taken) begin
                void'(pending_cmds.pop_front());
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    case (send_style)
                        SEND_STEADY: begin
                            burst_left = 1;
                            gap_left   = 0;
                        end
                        SEND_BURSTY: begin
                            burst_left = $urandom_range(16, 1);
                            gap_left   = $urandom_range(12, 0);
                        end
                        default: begin
                            burst_left = $urandom_range(3, 1);
                            gap_left   = $urandom_range(4, 1);
                        end
                    endcase
                end
            end
            // a stalled transaction stays on the bus unchanged
            if (cmd_valid && !cmd_taken) begin
            end else if (gap_left > 0) begin
                gap_left--;
                cmd_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cmd_valid <= 1'b1;
                cmd_data  <= pending_cmds[0];
            end else begin
                cmd_valid <= 1'b0;
            end
            cmd_taken = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern plus an occasional long hold-off
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        recv_step++;
        if (hold_left > 0) begin
            hold_left--;
            res_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            res_ready <= 1'b0;
        end else begin
            case (recv_style)
                RECV_FREE:   res_ready <= 1'b1;
                RECV_RANDOM: res_ready <= ($urandom_range(99, 0) < 70);
                default:     res_ready <= ((recv_step % 7) < 4);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in_item mk_cmd(input logic [1:0] op, input logic conn,
                                        input logic try_link, input logic lost,
                                        input logic [1:0] st);
        t_in_item c;
        c.command          = op;
        c.link_connected   = conn;
        c.link_connecting  = try_link;
        c.clock_lost_power = lost;
        c.new_status       = st;
        return c;
    endfunction

    // random register value between two bounds, sized to the write data
    function automatic logic [CFG_DATA_W-1:0] rnd_val(input int unsigned hi,
                                                      input int unsigned lo);
        return CFG_DATA_W'($urandom_range(hi, lo));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        reg_wr_valid <= 1'b1;
        reg_wr_data  <= '{index: idx, data: val};
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        reg_wr_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] l, input logic [CFG_DATA_W-1:0] c,
                                  input logic [CFG_DATA_W-1:0] h, input logic [CFG_DATA_W-1:0] f,
                                  input logic [CFG_DATA_W-1:0] b, input logic [CFG_DATA_W-1:0] n);
        write_reg(REG_LINK_BLINK, l);
        write_reg(REG_CLOCK_BLINK, c);
        write_reg(REG_HEARTBEAT, h);
        write_reg(REG_FAST_BLINK, f);
        write_reg(REG_BURST_BLINK, b);
        write_reg(REG_BURST_COUNT, n);
    endtask

    // all commands offered and every result back, plus the block's latency
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_leds.size() != 0 || cmd_valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random commands with link and clock inputs that flip now and then
    task automatic queue_random(input int n, input int flip_pct, input int tick_pct);
        t_in_item    c;
        int unsigned roll;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99, 0) < flip_pct) lk_conn  = ~lk_conn;
            if ($urandom_range(99, 0) < flip_pct) lk_try   = ~lk_try;
            if ($urandom_range(99, 0) < flip_pct) clk_lost = ~clk_lost;
            roll = $urandom_range(99, 0);
            if (roll < tick_pct) begin
                c.command = CMD_TICK;
            end else begin
                roll = $urandom_range(19, 0);
                c.command = (roll < 12) ? CMD_SET : (roll < 17) ? CMD_CLEAR : CMD_UNUSED;
            end
            c.link_connected   = lk_conn;
            c.link_connecting  = lk_try;
            c.clock_lost_power = clk_lost;
            c.new_status       = 2'($urandom_range(3, 0));
            pending_cmds.push_back(c);
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset periods, every command, connected over connecting
        pending_cmds.push_back(mk_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, MODE_NONE));
        pending_cmds.push_back(mk_cmd(CMD_TICK, 1'b1, 1'b1, 1'b1, MODE_SOLID));
        pending_cmds.push_back(mk_cmd(CMD_TICK, 1'b0, 1'b1, 1'b1, MODE_NONE));
        pending_cmds.push_back(mk_cmd(CMD_SET, 1'b1, 1'b0, 1'b1, MODE_FAST));
        pending_cmds.push_back(mk_cmd(CMD_SET, 1'b0, 1'b0, 1'b0, MODE_BURST));
        pending_cmds.push_back(mk_cmd(CMD_SET, 1'b0, 1'b0, 1'b0, MODE_SOLID));
        pending_cmds.push_back(mk_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, MODE_NONE));
        pending_cmds.push_back(mk_cmd(CMD_CLEAR, 1'b1, 1'b1, 1'b1, MODE_SOLID));
        pending_cmds.push_back(mk_cmd(CMD_SET, 1'b0, 1'b0, 1'b0, MODE_NONE));
        pending_cmds.push_back(mk_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, MODE_NONE));
        pending_cmds.push_back(mk_cmd(CMD_UNUSED, 1'b1, 1'b1, 1'b1, MODE_SOLID));
        wait_drained();

        // directed: period one, burst count masked to zero, unknown indexes
        apply_settings(12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'hFF0);
        write_reg(REG_SPARE_A, 12'hFFF);
        write_reg(REG_SPARE_B, 12'h5A5);
        pending_cmds.push_back(mk_cmd(CMD_SET, 1'b0, 1'b0, 1'b0, MODE_BURST));
        pending_cmds.push_back(mk_cmd(CMD_TICK, 1'b0, 1'b0, 1'b0, MODE_NONE));
        repeat (3) pending_cmds.push_back(mk_cmd(CMD_TICK, 1'b0, 1'b1, 1'b1, MODE_NONE));
        pending_cmds.push_back(mk_cmd(CMD_SET, 1'b0, 1'b1, 1'b1, MODE_FAST));
        repeat (2) pending_cmds.push_back(mk_cmd(CMD_TICK, 1'b0, 1'b1, 1'b1, MODE_NONE));
        wait_drained();

        // directed: zero periods toggle every tick, longest burst
        apply_settings(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd15);
        pending_cmds.push_back(mk_cmd(CMD_SET, 1'b0, 1'b1, 1'b1, MODE_BURST));
        repeat (4) pending_cmds.push_back(mk_cmd(CMD_TICK, 1'b0, 1'b1, 1'b1, MODE_NONE));
        pending_cmds.push_back(mk_cmd(CMD_CLEAR, 1'b0, 1'b0, 1'b0, MODE_NONE));
        wait_drained();

        // short periods, sticky inputs, bursty sender
        apply_settings(rnd_val(8, 1), rnd_val(8, 1), rnd_val(8, 1),
                       rnd_val(8, 1), rnd_val(8, 1), rnd_val(15, 0));
        send_style = SEND_BURSTY;
        recv_style = RECV_RANDOM;
        queue_random(PHASE_ITEMS, 8, 88);
        wait_drained();

        // period one and longest burst with no idling
        apply_settings(12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd15);
        send_style = SEND_STEADY;
        recv_style = RECV_FREE;
        queue_random(PHASE_ITEMS, 10, 92);
        wait_drained();

        // zero periods, burst ends on the first tick
        apply_settings(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_style = SEND_CHOPPY;
        recv_style = RECV_PATTERN;
        queue_random(PHASE_ITEMS, 20, 70);
        wait_drained();

        // mid periods; the receiver holds off while the sender keeps offering
        apply_settings(rnd_val(30, 5), rnd_val(30, 5), rnd_val(30, 5),
                       rnd_val(6, 2), rnd_val(6, 2), rnd_val(5, 1));
        send_style = SEND_STEADY;
        recv_style = RECV_RANDOM;
        queue_random(PHASE_ITEMS, 3, 93);
        repeat (20) @(posedge i_clk);
        hold_req = 1'b1;
        wait_drained();

        // full-range register values and noisy inputs
        apply_settings(rnd_val(4095, 0), rnd_val(4095, 0), rnd_val(4095, 0),
                       rnd_val(4095, 0), rnd_val(4095, 0), rnd_val(4095, 0));
        write_reg(REG_SPARE_A, rnd_val(4095, 0));
        write_reg(REG_SPARE_B, rnd_val(4095, 0));
        send_style = SEND_BURSTY;
        recv_style = RECV_PATTERN;
        queue_random(PHASE_ITEMS, 50, 60);
        wait_drained();

        // longest periods while link is held connected and clock healthy
        apply_settings(12'd4095, 12'd4095, 12'd4095, 12'd4095,
                       rnd_val(20, 1), rnd_val(15, 0));
        lk_conn  = 1'b1;
        lk_try   = 1'($urandom_range(1, 0));
        clk_lost = 1'b0;
        send_style = SEND_STEADY;
        recv_style = RECV_FREE;
        queue_random(PHASE_ITEMS, 0, 98);
        wait_drained();

        // release held inputs under the longest periods
        lk_conn  = 1'b0;
        lk_try   = 1'b1;
        clk_lost = 1'b1;
        send_style = SEND_BURSTY;
        recv_style = RECV_RANDOM;
        queue_random(PHASE_ITEMS, 2, 90);
        wait_drained();

        $display("run covered %0d commands, %0d results and %0d register writes,",
                 cmd_count, res_count, reg_count);
        $display("with zero, one, mid, random and longest periods and stalls on both sides");
        if (err_count == 0 && expected_leds.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
